[sv/assert_macros.svh]
// Assertion macros shared by the RTL files of the min/max subset selector.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("Same-cycle assertion failed.");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("Next-cycle assertion failed.");

`endif

[sv/mms_pkg.sv]
// Package of the min/max subset selector: widths, register map, cell and state types.
// No dependencies; every other file of the block but assert_macros.svh imports it.
package mms_pkg;

    localparam int KEEP_MAX_DEF = 32;
    localparam int ROWS_MAX     = 16384;
    localparam int ROW_W        = $clog2(ROWS_MAX);
    localparam int VALUE_W      = 32;
    localparam int KEY_W        = VALUE_W + ROW_W;
    localparam int KEEP_W       = 6;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_KEEP_COUNT = '0;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [ROW_W-1:0] row_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_APPEND,
        OP_REPLACE,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        key_t     key;
    } cell_ctl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

[sv/mms_in_if.sv]
// Input channel of the min/max subset selector: valid/ready plus one sample.
// Depends on mms_pkg for the field widths.
interface mms_in_if;
    import mms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    row_t                      row_number;
    logic                      column_end;

    modport source (output valid, sample_value, row_number, column_end, input ready);
    modport sink (input valid, sample_value, row_number, column_end, output ready);
endinterface

[sv/mms_out_if.sv]
// Output channel of the min/max subset selector: valid/ready plus one selected row.
// Depends on mms_pkg for the field widths.
interface mms_out_if;
    import mms_pkg::*;

    logic valid;
    logic ready;
    row_t chosen_row;
    logic from_large_set;
    logic final_result;

    modport source (output valid, chosen_row, from_large_set, final_result, input ready);
    modport sink (input valid, chosen_row, from_large_set, final_result, output ready);
endinterface

[sv/mms_cell.sv]
// One cell of a sorted key chain: holds one key and moves it to or from a neighbor.
// Depends on mms_pkg for the key and control types.
module mms_cell (
    input  logic              clk,
    input  mms_pkg::cell_ctl_t ctl,
    input  logic              occupied,
    input  mms_pkg::key_t     prev_key,
    input  logic              prev_hit,
    input  mms_pkg::key_t     next_key,
    input  logic              next_hit,
    output logic              hit,
    output mms_pkg::key_t     stored_key
);
    import mms_pkg::*;

    key_t key_reg;
    key_t key_next;

    assign hit        = occupied && (key_reg > ctl.key);
    assign stored_key = key_reg;

    always_comb
    begin
        key_next = key_reg;
        case (ctl.op)
            OP_APPEND:
            begin
                if (hit)
                begin
                    key_next = key_reg;
                end
                else if (prev_hit)
                begin
                    key_next = ctl.key;
                end
                else
                begin
                    key_next = prev_key;
                end
            end
            OP_REPLACE:
            begin
                if (next_hit)
                begin
                    key_next = next_key;
                end
                else if (hit)
                begin
                    key_next = ctl.key;
                end
                else
                begin
                    key_next = key_reg;
                end
            end
            OP_POP:
            begin
                key_next = next_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

[sv/mms_chain.sv]
// Chain of cells that keeps its keys sorted from largest at the head downward,
// with the fill count and the insert/replace/pop decision. Depends on mms_pkg, mms_cell.
module mms_chain #(
    parameter int CELLS = mms_pkg::KEEP_MAX_DEF,
    localparam int FILL_W = $clog2(CELLS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              insert,
    input  logic              pop,
    input  logic [FILL_W-1:0] eff,
    input  mms_pkg::key_t     new_key,
    output logic [FILL_W-1:0] fill,
    output mms_pkg::key_t     head_key
);
    import mms_pkg::*;

    logic [CELLS-1:0] hit;
    key_t             stored [CELLS];
    cell_ctl_t        ctl;
    logic             append;
    logic             replace;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    assign append  = insert && (fill_reg < eff);
    assign replace = insert && !append && (eff != '0) && (fill_reg != '0)
                     && (new_key[KEY_W-1 -: VALUE_W] < stored[0][KEY_W-1 -: VALUE_W]);

    always_comb
    begin
        ctl.key = new_key;
        if (append)
        begin
            ctl.op = OP_APPEND;
        end
        else if (replace)
        begin
            ctl.op = OP_REPLACE;
        end
        else if (pop)
        begin
            ctl.op = OP_POP;
        end
        else
        begin
            ctl.op = OP_HOLD;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (append)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && (fill_reg != '0))
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        key_t prev_key;
        logic prev_hit;
        key_t next_key;
        logic next_hit;

        if (i == 0)
        begin : g_first
            assign prev_key = new_key;
            assign prev_hit = 1'b1;
        end
        else
        begin : g_inner_prev
            assign prev_key = stored[i-1];
            assign prev_hit = hit[i-1];
        end

        if (i == CELLS - 1)
        begin : g_last
            assign next_key = stored[i];
            assign next_hit = 1'b0;
        end
        else
        begin : g_inner_next
            assign next_key = stored[i+1];
            assign next_hit = hit[i+1];
        end

        mms_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (fill_reg > FILL_W'(i)),
            .prev_key   (prev_key),
            .prev_hit   (prev_hit),
            .next_key   (next_key),
            .next_hit   (next_hit),
            .hit        (hit[i]),
            .stored_key (stored[i])
        );
    end

    assign fill     = fill_reg;
    assign head_key = stored[0];

endmodule

[sv/min_max_subset_selector.sv]
// Top level of the min/max subset selector: APB register, control and two cell chains.
// Depends on mms_pkg, mms_in_if, mms_out_if, mms_chain and assert_macros.svh.
//
// While a column streams in, the block takes one sample per clock cycle: each of its two
// chains of KEEP_MAX compare cells inserts the sample, or replaces its worst entry, in the
// cycle of the transfer. After the sample marked column_end the input is held off while
// the kept rows go out, one per cycle when the sink is ready: the smallest values from
// largest to smallest, then the largest values from smallest to largest, at most
// 2 * KEEP_MAX results (every kept row, even when keep_count was lowered within the
// column), the last one flagged final_result. keep_count (register 0) resets to 1; values
// above KEEP_MAX act as KEEP_MAX.
`include "assert_macros.svh"

module min_max_subset_selector #(
    parameter int KEEP_MAX = mms_pkg::KEEP_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mms_in_if.sink                         in_ch,
    mms_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mms_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mms_pkg::*;

    localparam int FILL_W = $clog2(KEEP_MAX + 1);

    logic [KEEP_W-1:0]     keep_count_reg;
    logic [APB_ADDR_W-3:0] reg_index;
    logic                  cfg_write;
    logic [FILL_W-1:0]     eff;

    state_t state_reg;
    state_t state_next;

    logic              in_transfer;
    logic              out_transfer;
    logic              last_transfer;
    logic              sets_empty;
    logic [VALUE_W-1:0] biased;
    key_t              small_key;
    key_t              large_key;
    logic              insert;
    logic              small_pop;
    logic              large_pop;
    logic [FILL_W-1:0] small_fill;
    logic [FILL_W-1:0] large_fill;
    key_t              small_head;
    key_t              large_head;
    logic              small_empty;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready && (reg_index == REG_KEEP_COUNT);
    assign prdata    = (reg_index == REG_KEEP_COUNT) ? APB_DATA_W'(keep_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_RESET;
        end
        else if (cfg_write)
        begin
            keep_count_reg <= pwdata[KEEP_W-1:0];
        end
    end

    assign eff = (keep_count_reg > KEEP_W'(KEEP_MAX)) ? FILL_W'(KEEP_MAX)
                                                      : FILL_W'(keep_count_reg);

    // Signed values become unsigned keys by flipping the sign bit; the large set
    // stores complemented keys so that both chains sort the same way.
    assign biased    = {~in_ch.sample_value[VALUE_W-1], in_ch.sample_value[VALUE_W-2:0]};
    assign small_key = {biased, in_ch.row_number};
    assign large_key = ~small_key;

    assign in_transfer   = in_ch.valid && in_ch.ready;
    assign out_transfer  = out_ch.valid && out_ch.ready;
    assign last_transfer = out_transfer && out_ch.final_result;
    assign sets_empty    = (small_fill == '0) && (large_fill == '0);
    assign insert        = in_transfer;
    assign small_empty   = (small_fill == '0);

    mms_chain #(
        .CELLS (KEEP_MAX)
    ) u_small_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .insert   (insert),
        .pop      (small_pop),
        .eff      (eff),
        .new_key  (small_key),
        .fill     (small_fill),
        .head_key (small_head)
    );

    mms_chain #(
        .CELLS (KEEP_MAX)
    ) u_large_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .insert   (insert),
        .pop      (large_pop),
        .eff      (eff),
        .new_key  (large_key),
        .fill     (large_fill),
        .head_key (large_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_transfer && in_ch.column_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_ch.valid || (out_transfer && out_ch.final_result))
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        in_ch.ready           = 1'b0;
        out_ch.valid          = 1'b0;
        small_pop             = 1'b0;
        large_pop             = 1'b0;
        out_ch.from_large_set = small_empty;
        out_ch.chosen_row     = small_empty ? ~large_head[ROW_W-1:0] : small_head[ROW_W-1:0];
        out_ch.final_result   = small_empty ? (large_fill == FILL_W'(1))
                                            : ((small_fill == FILL_W'(1)) && (large_fill == '0));
        case (state_reg)
            ST_COLLECT:
            begin
                in_ch.ready = 1'b1;
            end
            ST_EMIT:
            begin
                out_ch.valid = !small_empty || (large_fill != '0);
                small_pop    = out_transfer && !small_empty;
                large_pop    = out_transfer && small_empty;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    `ASSERT_NEXT(a_more_after_nonfinal, clk, rst_n, out_transfer && !last_transfer, out_ch.valid)
    `ASSERT_NEXT(a_empty_after_final, clk, rst_n, last_transfer, sets_empty)
    `ASSERT_IMPLIES(a_fills_match_collect, clk, rst_n, in_ch.ready, small_fill == large_fill)

endmodule
